FILE: src/bgr_delta_run_literal_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef BGR_DELTA_RUN_LITERAL_DECODER_DEFINES_SVH
`define BGR_DELTA_RUN_LITERAL_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BDRL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BDRL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bdrl_pkg.sv
package bdrl_pkg;

    localparam int NP_W    = 25;
    localparam int FRAME_W = 25;
    localparam logic [FRAME_W-1:0] FRAME_PIXELS_RESET = 25'h100_0000;

    // Parser position within the color stream.
    typedef enum logic [2:0] {
        PH_FLAG = 3'd0,
        PH_DLO  = 3'd1,
        PH_DHI  = 3'd2,
        PH_B    = 3'd3,
        PH_G    = 3'd4,
        PH_R    = 3'd5
    } parse_phase_t;

    // Top two bits of a flag byte.
    typedef enum logic [1:0] {
        FL_LITERAL = 2'b00,
        FL_RUN     = 2'b01,
        FL_DELTA   = 2'b10,
        FL_BAD     = 2'b11
    } flag_mode_t;

    typedef enum logic [1:0] {
        RS_OK        = 2'd0,
        RS_BAD_FLAG  = 2'd1,
        RS_OVERFLOW  = 2'd2,
        RS_TRUNCATED = 2'd3
    } result_status_t;

    // Result sequencer states.
    typedef enum logic [1:0] {
        EM_IDLE  = 2'd0,
        EM_RUN   = 2'd1,
        EM_TRUNC = 2'd2
    } emit_state_t;

    typedef struct packed {
        logic take_byte;
        logic run_step;
        logic trunc_step;
    } dp_cmd_t;

    typedef struct packed {
        logic first_valid;
        logic run_more;
        logic trunc_after;
        logic run_last;
    } dp_status_t;

endpackage

FILE: src/bgr_delta_run_literal_decoder.sv
// Color stream decoder: takes one compressed byte per transaction and returns
// BGR pixels in stream order, with an error result (zero color, nonzero status)
// for a bad flag, a frame overflow or a stream that ends inside an item. A byte
// that yields at most one result is taken every cycle while the result side keeps
// up. The byte that completes a run of N+1 pixels holds the input until its N more
// are out, and a pixel then a truncation error holds it for the error: all results
// leave through the single output register, one per cycle while m_ready is high,
// paced by the result sequencer. Write frame_pixels only while the block is idle.
module bgr_delta_run_literal_decoder
    import bdrl_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_start_frame,
    input  logic                        s_end_of_stream,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_blue,
    output logic [7:0]                  m_green,
    output logic [7:0]                  m_red,
    output logic [PIXEL_INDEX_BITS-1:0] m_pixel_index,
    output logic                        m_run_end,
    output logic [1:0]                  m_status,
    input  logic                        cfg_wr_en,
    input  logic [FRAME_W-1:0]          cfg_wr_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bdrl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bdrl_datapath #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_data_byte     (s_data_byte),
        .s_start_frame   (s_start_frame),
        .s_end_of_stream (s_end_of_stream),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .status          (status),
        .m_blue          (m_blue),
        .m_green         (m_green),
        .m_red           (m_red),
        .m_pixel_index   (m_pixel_index),
        .m_run_end       (m_run_end),
        .m_status        (m_status)
    );

endmodule

FILE: src/bdrl_ctrl.sv
module bdrl_ctrl
    import bdrl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    emit_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        slot_free    = !m_valid_reg || m_ready;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            EM_IDLE: begin
                s_ready = slot_free;
                if (s_valid && slot_free) begin
                    cmd.take_byte = 1'b1;
                    if (status.first_valid) begin
                        m_valid_next = 1'b1;
                    end
                    if (status.run_more) begin
                        state_next = EM_RUN;
                    end else if (status.trunc_after) begin
                        state_next = EM_TRUNC;
                    end
                end
            end
            EM_RUN: begin
                if (slot_free) begin
                    cmd.run_step = 1'b1;
                    m_valid_next = 1'b1;
                    if (status.run_last) begin
                        state_next = EM_IDLE;
                    end
                end
            end
            EM_TRUNC: begin
                if (slot_free) begin
                    cmd.trunc_step = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = EM_IDLE;
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: src/bdrl_datapath.sv
module bdrl_datapath
    import bdrl_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_start_frame,
    input  logic                        s_end_of_stream,
    input  logic                        cfg_wr_en,
    input  logic [FRAME_W-1:0]          cfg_wr_data,
    input  dp_cmd_t                     cmd,
    output dp_status_t                  status,
    output logic [7:0]                  m_blue,
    output logic [7:0]                  m_green,
    output logic [7:0]                  m_red,
    output logic [PIXEL_INDEX_BITS-1:0] m_pixel_index,
    output logic                        m_run_end,
    output logic [1:0]                  m_status
);

    parse_phase_t        phase_reg, phase_next;
    logic [6:0]          items_reg, items_next;
    logic [7:0]          blue_reg, blue_next;
    logic [7:0]          green_reg, green_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          dlo_reg, dlo_next;
    logic [NP_W-1:0]     np_reg, np_next;
    logic                fault_reg, fault_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [5:0]          run_left_reg, run_left_next;

    logic [7:0]            out_blue_reg, out_blue_next;
    logic [7:0]            out_green_reg, out_green_next;
    logic [7:0]            out_red_reg, out_red_next;
    logic [NP_W-1:0]       out_np_reg, out_np_next;
    logic                  out_run_end_reg, out_run_end_next;
    result_status_t        out_status_reg, out_status_next;

    // Frame-start view of the parser state
    parse_phase_t    eff_phase;
    logic [6:0]      eff_items;
    logic [7:0]      eff_blue, eff_green, eff_red, eff_dlo;
    logic [NP_W-1:0] eff_np;
    logic            eff_fault;

    logic [15:0]     word;
    logic [6:0]      items_dec;
    logic            ev_pixel, ev_bad, ev_run;
    logic            trunc;
    logic [NP_W-1:0] cmp_np;
    logic            ovf;
    logic [NP_W+PIXEL_INDEX_BITS-1:0] idx_ext;

    function automatic logic [7:0] step4(input logic [7:0] c, input logic [3:0] mag,
                                         input logic neg);
        logic [7:0] m8;
        m8 = {4'd0, mag};
        return neg ? (c - m8) : (c + m8);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FLAG;
            items_reg    <= '0;
            blue_reg     <= '0;
            green_reg    <= '0;
            red_reg      <= '0;
            dlo_reg      <= '0;
            np_reg       <= '0;
            fault_reg    <= 1'b0;
            frame_reg    <= FRAME_PIXELS_RESET;
            run_left_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            items_reg    <= items_next;
            blue_reg     <= blue_next;
            green_reg    <= green_next;
            red_reg      <= red_next;
            dlo_reg      <= dlo_next;
            np_reg       <= np_next;
            fault_reg    <= fault_next;
            frame_reg    <= frame_next;
            run_left_reg <= run_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_blue_reg    <= out_blue_next;
        out_green_reg   <= out_green_next;
        out_red_reg     <= out_red_next;
        out_np_reg      <= out_np_next;
        out_run_end_reg <= out_run_end_next;
        out_status_reg  <= out_status_next;
    end

    always_comb begin
        if (s_start_frame) begin
            eff_phase = PH_FLAG;
            eff_items = '0;
            eff_blue  = '0;
            eff_green = '0;
            eff_red   = '0;
            eff_dlo   = '0;
            eff_np    = '0;
            eff_fault = 1'b0;
        end else begin
            eff_phase = phase_reg;
            eff_items = items_reg;
            eff_blue  = blue_reg;
            eff_green = green_reg;
            eff_red   = red_reg;
            eff_dlo   = dlo_reg;
            eff_np    = np_reg;
            eff_fault = fault_reg;
        end

        // One overflow compare, shared by byte intake and run steps
        cmp_np = cmd.take_byte ? eff_np : np_reg;
        ovf    = cmp_np >= frame_reg;

        word      = {s_data_byte, eff_dlo};
        items_dec = eff_items - 7'd1;

        phase_next    = phase_reg;
        items_next    = items_reg;
        blue_next     = blue_reg;
        green_next    = green_reg;
        red_next      = red_reg;
        dlo_next      = dlo_reg;
        np_next       = np_reg;
        fault_next    = fault_reg;
        run_left_next = run_left_reg;
        frame_next    = cfg_wr_en ? cfg_wr_data : frame_reg;

        out_blue_next    = out_blue_reg;
        out_green_next   = out_green_reg;
        out_red_next     = out_red_reg;
        out_np_next      = out_np_reg;
        out_run_end_next = out_run_end_reg;
        out_status_next  = out_status_reg;

        ev_pixel = 1'b0;
        ev_bad   = 1'b0;
        ev_run   = 1'b0;
        trunc    = 1'b0;
        status   = '0;

        if (cmd.take_byte) begin
            phase_next = eff_phase;
            items_next = eff_items;
            blue_next  = eff_blue;
            green_next = eff_green;
            red_next   = eff_red;
            dlo_next   = eff_dlo;
            np_next    = eff_np;
            fault_next = eff_fault;

            if (!eff_fault) begin
                unique case (eff_phase)
                    PH_DLO: begin
                        dlo_next   = s_data_byte;
                        phase_next = PH_DHI;
                    end
                    PH_DHI: begin
                        if (word[15]) begin
                            blue_next  = eff_blue + {3'd0, word[4:0]};
                            green_next = eff_green + {3'd0, word[9:5]};
                            red_next   = eff_red + {3'd0, word[14:10]};
                        end else begin
                            blue_next  = step4(eff_blue, word[3:0], word[4]);
                            green_next = step4(eff_green, word[8:5], word[9]);
                            red_next   = step4(eff_red, word[13:10], word[14]);
                        end
                        items_next = items_dec;
                        phase_next = (items_dec != '0) ? PH_DLO : PH_FLAG;
                        ev_pixel   = 1'b1;
                    end
                    PH_B: begin
                        blue_next  = s_data_byte;
                        phase_next = PH_G;
                    end
                    PH_G: begin
                        green_next = s_data_byte;
                        phase_next = PH_R;
                    end
                    PH_R: begin
                        red_next = s_data_byte;
                        ev_pixel = 1'b1;
                        if (eff_items[6]) begin
                            ev_run     = 1'b1;
                            items_next = '0;
                            phase_next = PH_FLAG;
                        end else if (items_dec[5:0] != '0) begin
                            items_next = items_dec;
                            phase_next = PH_B;
                        end else begin
                            items_next = '0;
                            phase_next = PH_FLAG;
                        end
                    end
                    default: begin
                        unique case (flag_mode_t'(s_data_byte[7:6]))
                            FL_DELTA: begin
                                items_next = {1'b0, s_data_byte[5:0]};
                                phase_next = (s_data_byte[5:0] != '0) ? PH_DLO : PH_FLAG;
                            end
                            FL_RUN: begin
                                items_next = {1'b1, s_data_byte[5:0]};
                                phase_next = PH_B;
                            end
                            FL_LITERAL: begin
                                items_next = {1'b0, s_data_byte[5:0]};
                                phase_next = (s_data_byte[5:0] != '0) ? PH_B : PH_FLAG;
                            end
                            FL_BAD: begin
                                items_next = '0;
                                phase_next = PH_FLAG;
                                ev_bad     = 1'b1;
                                fault_next = 1'b1;
                            end
                            default: begin
                                phase_next = PH_FLAG;
                            end
                        endcase
                    end
                endcase
            end

            // Pixel of this byte, or overflow in its place
            if (ev_pixel) begin
                if (ovf) begin
                    fault_next = 1'b1;
                end else begin
                    np_next = eff_np + NP_W'(1);
                end
            end
            if (ev_run) begin
                run_left_next = eff_items[5:0];
            end
            status.run_more = ev_run && !ovf && (eff_items[5:0] != '0);

            if (s_end_of_stream && !fault_next) begin
                trunc      = (phase_next != PH_FLAG);
                fault_next = trunc;
                phase_next = PH_FLAG;
                items_next = '0;
            end

            status.first_valid = ev_pixel || ev_bad || trunc;
            status.trunc_after = (ev_pixel || ev_bad) && trunc;

            out_np_next = eff_np;
            if (ev_pixel && !ovf) begin
                out_blue_next   = blue_next;
                out_green_next  = green_next;
                out_red_next    = red_next;
                out_status_next = RS_OK;
            end else begin
                out_blue_next  = '0;
                out_green_next = '0;
                out_red_next   = '0;
                if (ev_pixel) begin
                    out_status_next = RS_OVERFLOW;
                end else if (ev_bad) begin
                    out_status_next = RS_BAD_FLAG;
                end else begin
                    out_status_next = RS_TRUNCATED;
                end
            end
            out_run_end_next = !(status.run_more || status.trunc_after);
        end else if (cmd.run_step) begin
            out_np_next      = np_reg;
            out_run_end_next = ovf || (run_left_reg == 6'd1);
            if (ovf) begin
                fault_next      = 1'b1;
                run_left_next   = '0;
                out_blue_next   = '0;
                out_green_next  = '0;
                out_red_next    = '0;
                out_status_next = RS_OVERFLOW;
            end else begin
                np_next         = np_reg + NP_W'(1);
                run_left_next   = run_left_reg - 6'd1;
                out_blue_next   = blue_reg;
                out_green_next  = green_reg;
                out_red_next    = red_reg;
                out_status_next = RS_OK;
            end
        end else if (cmd.trunc_step) begin
            out_np_next      = np_reg;
            out_run_end_next = 1'b1;
            out_blue_next    = '0;
            out_green_next   = '0;
            out_red_next     = '0;
            out_status_next  = RS_TRUNCATED;
        end

        status.run_last = ovf || (run_left_reg == 6'd1);
    end

    assign idx_ext       = {PIXEL_INDEX_BITS'(0), out_np_reg};
    assign m_pixel_index = idx_ext[PIXEL_INDEX_BITS-1:0];
    assign m_blue        = out_blue_reg;
    assign m_green       = out_green_reg;
    assign m_red         = out_red_reg;
    assign m_run_end     = out_run_end_reg;
    assign m_status      = out_status_reg;

endmodule

FILE: src/bdrl_checker.sv
`include "bgr_delta_run_literal_decoder_defines.svh"

module bdrl_checker
    import bdrl_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [7:0]                  m_blue,
    input logic [7:0]                  m_green,
    input logic [7:0]                  m_red,
    input logic [PIXEL_INDEX_BITS-1:0] m_pixel_index,
    input logic                        m_run_end,
    input logic [1:0]                  m_status
);

    logic is_error;

    assign is_error = (m_status != RS_OK);

    // A stalled result holds until the transaction completes
    `BDRL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_blue) && $stable(m_green) && $stable(m_red) && $stable(m_pixel_index) && $stable(m_run_end) && $stable(m_status), "result changed while stalled")

    `BDRL_ASSERT_NOW(a_err_black, aclk, aresetn, m_valid && is_error, m_blue == 8'd0 && m_green == 8'd0 && m_red == 8'd0, "error result carries a color")

    // Nothing follows an error within its byte
    `BDRL_ASSERT_NOW(a_err_last, aclk, aresetn, m_valid && is_error, m_run_end, "error result not last of its byte")

    // Hold the input while a byte still owes results
    `BDRL_ASSERT_NOW(a_no_take_mid, aclk, aresetn, m_valid && !m_run_end, !s_ready, "input taken before byte's results finished")

endmodule

bind bgr_delta_run_literal_decoder bdrl_checker #(
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
) u_bdrl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_blue        (m_blue),
    .m_green       (m_green),
    .m_red         (m_red),
    .m_pixel_index (m_pixel_index),
    .m_run_end     (m_run_end),
    .m_status      (m_status)
);
